/* design/binary_mask_thinning_color_spread_defines.svh */
// Assertion macros for the binary mask thinning block.
// Included by the top level; no other dependencies.
`ifndef BINARY_MASK_THINNING_COLOR_SPREAD_DEFINES_SVH
`define BINARY_MASK_THINNING_COLOR_SPREAD_DEFINES_SVH
`ifndef SYNTHESIS
`define BMT_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bmt assertion failed");
`define BMT_ASSERT_IMPLIES(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("bmt assertion failed");
`define BMT_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("bmt assertion failed");
`else
`define BMT_ASSERT_NEVER(label, expr)
`define BMT_ASSERT_IMPLIES(label, lhs, rhs)
`define BMT_ASSERT_NEXT(label, lhs, rhs)
`endif
`endif

/* design/bmt_pkg.sv */
// Shared types, constants and the removal table of the thinning block.
// No dependencies.
package bmt_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int PIX_W  = 17;
    localparam int MAP_W  = 9;
    localparam int ITER_W = 17;
    localparam int CFG_W  = 9;
    localparam logic [ITER_W-1:0] ITER_LIMIT = 17'd65537;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_S = 2'd1,
        DIR_W = 2'd2,
        DIR_E = 2'd3
    } dir_t;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_READ = 2'd1,
        RES_RUN  = 2'd2
    } res_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_RD,
        S_ROW_LD,
        S_PIX_RD,
        S_PIX_EV,
        S_NB_WR
    } state_t;

    localparam logic [MAP_W-1:0] MAP_TOP_FILL = 9'o077;
    localparam logic [MAP_W-1:0] MAP_KEEP     = 9'o770;

    // index 0 is the leftmost bit
    localparam logic [0:511] REMOVAL = {
        32'h00001373, 32'h00003B33, 32'h000000F3, 32'h00000033,
        32'h000000F3, 32'h0000BBFF, 32'h000080F3, 32'h0000BBFF,
        32'h00000000, 32'h0000BB33, 32'h00000000, 32'h00000033,
        32'h000080F3, 32'h0000BBFF, 32'h000080F3, 32'h0000BBFF
    };

    function automatic logic [MAP_W-1:0] side_bit(input dir_t d);
        logic [MAP_W-1:0] s;
        unique case (d)
            DIR_N:   s = 9'o200;
            DIR_S:   s = 9'o002;
            DIR_W:   s = 9'o040;
            DIR_E:   s = 9'o010;
            default: s = 9'o200;
        endcase
        return s;
    endfunction

endpackage

/* design/bmt_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module bmt_ram #(
    parameter int DW = 17,
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/binary_mask_thinning_color_spread.sv */
// Top level of the binary mask thinning block: command port, sequencer, map line buffer.
// Depends on bmt_pkg, bmt_ram and binary_mask_thinning_color_spread_defines.svh.
// Write and read words are taken one per cycle while the block is idle; each gives its
// result strobe (done) on the next cycle. A run word holds busy high while the sequencer
// walks the pixel store: per sub-pass (h+1) rows of w pixels, with a row read and row load
// state per row, a read and evaluate state per pixel and a neighbour write state per cleared
// pixel; four sub-passes per iteration, repeated until an iteration changes nothing. done is
// strobed for one cycle and cannot be held off by the receiver.
`include "binary_mask_thinning_color_spread_defines.svh"

module binary_mask_thinning_color_spread #(
    parameter int MAX_WIDTH  = bmt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmt_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic [1:0]  op,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    input  logic        thin_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        thin_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [16:0] iterations
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int XC = $clog2(MAX_WIDTH + 1);
    localparam int YC = $clog2(MAX_HEIGHT + 1);
    localparam int AW = XW + YW;
    localparam int CW = 13;

    bmt_pkg::state_t                 state_reg, state_next;
    bmt_pkg::dir_t                   dir_reg, dir_next;
    bmt_pkg::res_kind_t              kind_reg, kind_next;
    logic [XC-1:0]                   x_reg, x_next;
    logic [YC-1:0]                   yn_reg, yn_next;
    logic [XC-1:0]                   w_reg, w_next;
    logic [YC-1:0]                   h_reg, h_next;
    logic                            a_reg, a_next;
    logic                            b_reg, b_next;
    logic                            oob_reg, oob_next;
    logic                            changed_reg, changed_next;
    logic [bmt_pkg::ITER_W-1:0]      iter_reg, iter_next;
    logic [bmt_pkg::ITER_W-1:0]      iter_out_reg, iter_out_next;
    logic                            done_reg, done_next;
    logic                            inside_reg, inside_next;
    logic [bmt_pkg::CFG_W-1:0]       rw_reg, rh_reg;

    logic                            st_we;
    logic [AW-1:0]                   st_waddr, st_raddr;
    logic [bmt_pkg::PIX_W-1:0]       st_wdata, st_rdata;

    logic [bmt_pkg::MAP_W-1:0]       buf_mem [MAX_WIDTH];
    logic [bmt_pkg::MAP_W-1:0]       buf_rdata;
    logic                            buf_we;
    logic [XW-1:0]                   buf_addr;
    logic [bmt_pkg::MAP_W-1:0]       buf_wdata;

    logic                            cmd_inside;
    logic                            c_bit;
    logic [bmt_pkg::MAP_W-1:0]       prev_map, cur_map;
    logic                            remove;
    logic [XC-1:0]                   x_inc;
    logic [XC-1:0]                   w_clamp;
    logic [YC-1:0]                   h_clamp;
    logic [XC-1:0]                   nb_x;
    logic [YC-1:0]                   nb_y;
    logic                            advance;
    logic [bmt_pkg::ITER_W-1:0]      iter_inc;

    bmt_ram #(
        .DW(bmt_pkg::PIX_W),
        .AW(AW)
    ) u_store (
        .clk  (clk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_addr] <= buf_wdata;
        end
        buf_rdata <= buf_mem[buf_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg <= bmt_pkg::CFG_W'(256);
            rh_reg <= bmt_pkg::CFG_W'(256);
        end
        else if (cfg_write)
        begin
            unique case (bmt_pkg::reg_idx_t'(cfg_index))
                bmt_pkg::REG_WIDTH:  rw_reg <= cfg_data;
                bmt_pkg::REG_HEIGHT: rh_reg <= cfg_data;
                default:             rw_reg <= rw_reg;
            endcase
        end
    end

    always_comb
    begin
        if (rw_reg == '0)
            w_clamp = XC'(1);
        else if (CW'(rw_reg) > CW'(MAX_WIDTH))
            w_clamp = XC'(MAX_WIDTH);
        else
            w_clamp = XC'(rw_reg);
        if (rh_reg == '0)
            h_clamp = YC'(1);
        else if (CW'(rh_reg) > CW'(MAX_HEIGHT))
            h_clamp = YC'(MAX_HEIGHT);
        else
            h_clamp = YC'(rh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bmt_pkg::S_IDLE;
            dir_reg      <= bmt_pkg::DIR_N;
            kind_reg     <= bmt_pkg::RES_NONE;
            changed_reg  <= 1'b0;
            iter_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dir_reg      <= dir_next;
            kind_reg     <= kind_next;
            changed_reg  <= changed_next;
            iter_reg     <= iter_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        yn_reg       <= yn_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        oob_reg      <= oob_next;
        iter_out_reg <= iter_out_next;
        inside_reg   <= inside_next;
    end

    assign cmd_inside = (CW'(col) < CW'(MAX_WIDTH)) && (CW'(row) < CW'(MAX_HEIGHT));
    assign c_bit      = oob_reg | st_rdata[bmt_pkg::PIX_W-1];
    assign prev_map   = (yn_reg == '0) ? bmt_pkg::MAP_TOP_FILL : buf_rdata;
    assign cur_map    = ((prev_map << 3) & bmt_pkg::MAP_KEEP) | {6'b0, a_reg, b_reg, c_bit};
    assign remove     = (yn_reg != '0) && ((cur_map & bmt_pkg::side_bit(dir_reg)) == '0)
                        && bmt_pkg::REMOVAL[cur_map];
    assign x_inc      = x_reg + XC'(1);
    assign iter_inc   = (iter_reg < bmt_pkg::ITER_LIMIT) ? iter_reg + 1'b1 : iter_reg;

    always_comb
    begin
        nb_x = x_reg;
        nb_y = yn_reg - YC'(1);
        unique case (dir_reg)
            bmt_pkg::DIR_N: nb_y = yn_reg - YC'(2);
            bmt_pkg::DIR_S: nb_y = yn_reg;
            bmt_pkg::DIR_W: nb_x = x_reg - XC'(1);
            bmt_pkg::DIR_E: nb_x = x_inc;
            default:        nb_x = x_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        dir_next      = dir_reg;
        kind_next     = bmt_pkg::RES_NONE;
        x_next        = x_reg;
        yn_next       = yn_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        oob_next      = oob_reg;
        changed_next  = changed_reg;
        iter_next     = iter_reg;
        iter_out_next = iter_out_reg;
        done_next     = 1'b0;
        inside_next   = inside_reg;
        st_we         = 1'b0;
        st_waddr      = {YW'(yn_reg - YC'(1)), XW'(x_reg)};
        st_wdata      = {1'b0, st_rdata[bmt_pkg::PIX_W-2:0]};
        st_raddr      = {YW'(yn_reg), XW'(x_inc)};
        buf_we        = 1'b0;
        buf_addr      = XW'(x_reg);
        buf_wdata     = cur_map;
        advance       = 1'b0;

        unique case (state_reg)
            bmt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    done_next   = (bmt_pkg::op_t'(op) != bmt_pkg::OP_RUN);
                    inside_next = cmd_inside;
                    st_raddr    = {YW'(row), XW'(col)};
                    st_waddr    = {YW'(row), XW'(col)};
                    st_wdata    = {thin_in, green_in, blue_in};
                    unique case (bmt_pkg::op_t'(op))
                        bmt_pkg::OP_WRITE:
                        begin
                            st_we = cmd_inside;
                        end
                        bmt_pkg::OP_READ:
                        begin
                            kind_next = bmt_pkg::RES_READ;
                        end
                        bmt_pkg::OP_RUN:
                        begin
                            w_next       = w_clamp;
                            h_next       = h_clamp;
                            iter_next    = '0;
                            changed_next = 1'b0;
                            dir_next     = bmt_pkg::DIR_N;
                            yn_next      = '0;
                            state_next   = bmt_pkg::S_ROW_RD;
                        end
                        default:
                        begin
                            kind_next = bmt_pkg::RES_NONE;
                        end
                    endcase
                end
            end
            bmt_pkg::S_ROW_RD:
            begin
                st_raddr   = {YW'(yn_reg), XW'(0)};
                oob_next   = (yn_reg >= h_reg);
                state_next = bmt_pkg::S_ROW_LD;
            end
            bmt_pkg::S_ROW_LD:
            begin
                a_next     = 1'b1;
                b_next     = c_bit;
                x_next     = '0;
                state_next = bmt_pkg::S_PIX_RD;
            end
            bmt_pkg::S_PIX_RD:
            begin
                oob_next   = (x_inc >= w_reg) || (yn_reg >= h_reg);
                state_next = bmt_pkg::S_PIX_EV;
            end
            bmt_pkg::S_PIX_EV:
            begin
                buf_we   = 1'b1;
                a_next   = b_reg;
                b_next   = c_bit;
                st_raddr = {YW'(nb_y), XW'(nb_x)};
                if (remove)
                    state_next = bmt_pkg::S_NB_WR;
                else
                    advance = 1'b1;
            end
            bmt_pkg::S_NB_WR:
            begin
                st_we        = 1'b1;
                changed_next = 1'b1;
                advance      = 1'b1;
            end
            default:
            begin
                state_next = bmt_pkg::S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (x_inc != w_reg)
            begin
                x_next     = x_inc;
                state_next = bmt_pkg::S_PIX_RD;
            end
            else if (yn_reg != h_reg)
            begin
                yn_next    = yn_reg + YC'(1);
                state_next = bmt_pkg::S_ROW_RD;
            end
            else if (dir_reg != bmt_pkg::DIR_E)
            begin
                dir_next   = bmt_pkg::dir_t'(dir_reg + 2'd1);
                yn_next    = '0;
                state_next = bmt_pkg::S_ROW_RD;
            end
            else
            begin
                iter_next = iter_inc;
                yn_next   = '0;
                dir_next  = bmt_pkg::DIR_N;
                if (changed_next)
                begin
                    changed_next = 1'b0;
                    state_next   = bmt_pkg::S_ROW_RD;
                end
                else
                begin
                    iter_out_next = iter_inc;
                    kind_next     = bmt_pkg::RES_RUN;
                    done_next     = 1'b1;
                    state_next    = bmt_pkg::S_IDLE;
                end
            end
        end
    end

    assign busy       = (state_reg != bmt_pkg::S_IDLE);
    assign done       = done_reg;
    assign thin_out   = (kind_reg == bmt_pkg::RES_READ) && inside_reg
                        && st_rdata[bmt_pkg::PIX_W-1];
    assign green_out  = ((kind_reg == bmt_pkg::RES_READ) && inside_reg) ? st_rdata[15:8] : 8'd0;
    assign blue_out   = ((kind_reg == bmt_pkg::RES_READ) && inside_reg) ? st_rdata[7:0] : 8'd0;
    assign iterations = (kind_reg == bmt_pkg::RES_RUN) ? iter_out_reg : '0;

    `BMT_ASSERT_NEVER(a_iter_limit, iter_reg > bmt_pkg::ITER_LIMIT)
    `BMT_ASSERT_IMPLIES(a_done_idle, done, !busy)
    `BMT_ASSERT_NEXT(a_quick_result, start && !busy && op != bmt_pkg::OP_RUN, done && !busy)

endmodule

/* dv/tb_top.sv */
// Testbench of binary_mask_thinning_color_spread: directed and random command words,
// checked against an in-bench model of the pixel store and the thinning run.
// Depends on bmt_pkg and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bmt_pkg::op_t op;
        logic [7:0]   col;
        logic [7:0]   row;
        logic         thin;
        logic [7:0]   green;
        logic [7:0]   blue;
    } word_t;

    typedef struct {
        logic        thin;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [16:0] iters;
    } pixel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        done;
    logic        cfg_write = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic [1:0]  op = '0;
    logic [7:0]  col = '0;
    logic [7:0]  row = '0;
    logic        thin_in = 1'b0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic        thin_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [16:0] iterations;

    binary_mask_thinning_color_spread DUT (.*);

    always #5 clk = ~clk;

    // removal table, 32 entries per word, entry 0 in the msb
    localparam logic [31:0] KILL_TBL [16] = '{
        32'h00001373, 32'h00003B33, 32'h000000F3, 32'h00000033,
        32'h000000F3, 32'h0000BBFF, 32'h000080F3, 32'h0000BBFF,
        32'h00000000, 32'h0000BB33, 32'h00000000, 32'h00000033,
        32'h000080F3, 32'h0000BBFF, 32'h000080F3, 32'h0000BBFF
    };

    logic [16:0] pix_mem [65536];
    int          roi_w = 256;
    int          roi_h = 256;
    bit          gen_written [65536];

    word_t         pending_words[$];
    pixel_result_t expected_pixels[$];
    word_t         cur;
    int            send_idle_pct = 0;
    int            mismatches = 0;

    function automatic logic thin_at(int x, int y, int w, int h);
        if (x < 0 || y < 0 || x >= w || y >= h) return 1'b1;
        return pix_mem[y*256 + x][16];
    endfunction

    function automatic logic [2:0] triple_at(int x, int y, int w, int h);
        return {thin_at(x-1, y, w, h), thin_at(x, y, w, h), thin_at(x+1, y, w, h)};
    endfunction

    function automatic bit thin_side(int d, int w, int h);
        logic [8:0] line_map [256];
        logic [8:0] m;
        logic [8:0] sbit;
        int dx, dy, nx, ny, idx;
        bit chg;
        chg = 0;
        case (d)
            bmt_pkg::DIR_N:
            begin
                sbit = 9'o200; dx = 0;  dy = -1;
            end
            bmt_pkg::DIR_S:
            begin
                sbit = 9'o002; dx = 0;  dy = 1;
            end
            bmt_pkg::DIR_W:
            begin
                sbit = 9'o040; dx = -1; dy = 0;
            end
            default:
            begin
                sbit = 9'o010; dx = 1; dy = 0;
            end
        endcase
        for (int x = 0; x < w; x++)
            line_map[x] = 9'o770 | triple_at(x, 0, w, h);
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                m = ((line_map[x] << 3) & 9'o770) | triple_at(x, y+1, w, h);
                line_map[x] = m;
                idx = m;
                if ((m & sbit) == 0 && KILL_TBL[idx/32][31 - idx%32])
                begin
                    nx = x + dx;
                    ny = y + dy;
                    if (nx >= 0 && ny >= 0 && nx < w && ny < h)
                    begin
                        pix_mem[y*256 + x] = {1'b0, pix_mem[ny*256 + nx][15:0]};
                        chg = 1;
                    end
                end
            end
        end
        return chg;
    endfunction

    function automatic pixel_result_t apply_word(word_t wd);
        pixel_result_t r;
        int w, h, n;
        bit chg;
        r = '{1'b0, 8'd0, 8'd0, 17'd0};
        case (wd.op)
            bmt_pkg::OP_WRITE: pix_mem[{wd.row, wd.col}] = {wd.thin, wd.green, wd.blue};
            bmt_pkg::OP_READ: {r.thin, r.green, r.blue} = pix_mem[{wd.row, wd.col}];
            bmt_pkg::OP_RUN:
            begin
                w = roi_w < 1 ? 1 : (roi_w > 256 ? 256 : roi_w);
                h = roi_h < 1 ? 1 : (roi_h > 256 ? 256 : roi_h);
                n = 0;
                do
                begin
                    chg = 0;
                    for (int d = 0; d < 4; d++)
                        if (thin_side(d, w, h)) chg = 1;
                    if (n < 65537) n++;
                end
                while (chg);
                r.iters = n;
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
                expected_pixels.push_back(apply_word(cur));
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur = pending_words.pop_front();
                op <= cur.op;
                col <= cur.col;
                row <= cur.row;
                thin_in <= cur.thin;
                green_in <= cur.green;
                blue_in <= cur.blue;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pixel_result_t e;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: thin %0d g %0d b %0d iter %0d",
                             thin_out, green_out, blue_out, iterations);
            end
            else
            begin
                e = expected_pixels.pop_front();
                if (thin_out !== e.thin || green_out !== e.green || blue_out !== e.blue
                    || iterations !== e.iters)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp thin %0d g %0d b %0d iter %0d, %s %0d %0d %0d %0d",
                                 e.thin, e.green, e.blue, e.iters, "got",
                                 thin_out, green_out, blue_out, iterations);
                end
            end
        end
    end

    task automatic push_word(bmt_pkg::op_t o, int c, int r, bit t, int g, int b);
        word_t wd;
        wd = '{o, c[7:0], r[7:0], t, g[7:0], b[7:0]};
        if (o == bmt_pkg::OP_WRITE) gen_written[{wd.row, wd.col}] = 1;
        pending_words.push_back(wd);
    endtask

    task automatic drain();
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (start || busy || expected_pixels.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_region(int w, int h);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= bmt_pkg::REG_WIDTH;
        cfg_data <= w[8:0];
        @(posedge clk);
        cfg_index <= bmt_pkg::REG_HEIGHT;
        cfg_data <= h[8:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        roi_w = w;
        roi_h = h;
    endtask

    task automatic fill_region(int w, int h, int thin_pct);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                push_word(bmt_pkg::OP_WRITE, x, y, $urandom_range(99) < thin_pct,
                          $urandom_range(255), $urandom_range(255));
    endtask

    task automatic read_random();
        int a;
        do a = $urandom_range(65535); while (!gen_written[a]);
        push_word(bmt_pkg::OP_READ, a % 256, a / 256, 0, 0, 0);
    endtask

    initial
    begin
        int w, h, a;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small block, filled but for one empty corner
        set_region(4, 3);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 4; x++)
                push_word(bmt_pkg::OP_WRITE, x, y, !(x == 3 && y == 2), 16*x + y,
                          255 - 16*x - y);
        push_word(bmt_pkg::OP_WRITE, 255, 255, 1, 255, 255);
        push_word(bmt_pkg::OP_READ, 255, 255, 0, 0, 0);
        push_word(bmt_pkg::OP_NONE, 170, 85, 1, 255, 255);
        push_word(bmt_pkg::OP_RUN, 0, 0, 0, 0, 0);
        push_word(bmt_pkg::OP_READ, 0, 0, 0, 0, 0);
        push_word(bmt_pkg::OP_READ, 3, 2, 0, 0, 0);
        push_word(bmt_pkg::OP_READ, 1, 1, 0, 0, 0);
        push_word(bmt_pkg::OP_RUN, 0, 0, 0, 0, 0);
        drain();

        // extremes: zero width acts as one, oversize height as the maximum
        set_region(0, 511);
        fill_region(1, 256, 80);
        push_word(bmt_pkg::OP_RUN, 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++) read_random();
        drain();
        set_region(256, 1);
        fill_region(256, 1, 80);
        push_word(bmt_pkg::OP_RUN, 0, 0, 0, 0, 0);
        push_word(bmt_pkg::OP_READ, 255, 0, 0, 0, 0);
        drain();
        set_region(1, 1);
        push_word(bmt_pkg::OP_RUN, 0, 0, 0, 0, 0);
        drain();

        for (int seg = 0; seg < 12; seg++)
        begin
            send_idle_pct = seg < 4 ? 31 : (seg < 8 ? 69 : 0);
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 10);
            set_region(w, h);
            fill_region(w, h, $urandom_range(40, 95));
            push_word(bmt_pkg::OP_RUN, 0, 0, 0, 0, 0);
            for (int i = 0; i < 25; i++)
            begin
                a = $urandom_range(99);
                if (a < 40)
                    push_word(bmt_pkg::OP_WRITE, $urandom_range(w-1), $urandom_range(h-1),
                              $urandom_range(99) < 70, $urandom_range(255),
                              $urandom_range(255));
                else if (a < 55)
                    push_word(bmt_pkg::OP_WRITE, $urandom_range(255), $urandom_range(255),
                              $urandom_range(1), $urandom_range(255), $urandom_range(255));
                else if (a < 90)
                    read_random();
                else if (a < 95)
                    push_word(bmt_pkg::OP_RUN, $urandom_range(255), $urandom_range(255),
                              $urandom_range(1), $urandom_range(255), $urandom_range(255));
                else
                    push_word(bmt_pkg::OP_NONE, $urandom_range(255), $urandom_range(255),
                              $urandom_range(1), $urandom_range(255), $urandom_range(255));
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("[binary_mask_thinning_color_spread] OK");
        else
            $display("[binary_mask_thinning_color_spread] ERROR");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("[binary_mask_thinning_color_spread] ERROR");
        $finish;
    end
endmodule
